// ===== rtl/lwps_pkg.sv =====
// Shared types and constants of the latency weighted path selector.
`timescale 1ns / 1ps
package lwps_pkg;

  // Action codes of the input channel
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_SLOT   = 1'b1;

  // Configuration register indexes and port geometry
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [1:0] REG_NUM_PATHS     = 2'd0;
  localparam logic [1:0] REG_UPDATE_PERIOD = 2'd1;
  localparam logic [1:0] REG_EMPTY_LATENCY = 2'd2;

  localparam logic [4:0]  NUM_PATHS_RST     = 5'd2;
  localparam logic [15:0] UPDATE_PERIOD_RST = 16'd1000;
  localparam logic [31:0] EMPTY_LATENCY_RST = 32'd1000000;

  // Weight is 2^WEIGHT_SHIFT / average, so it needs one bit more
  localparam int unsigned WEIGHT_SHIFT = 40;
  localparam int unsigned WEIGHT_W     = WEIGHT_SHIFT + 1;

  // Slot remainder is taken one bit per cycle
  localparam int unsigned SLOT_W = 32;
  localparam int unsigned STEP_W = 5;

  typedef enum logic [1:0] {
    CMD_IGNORE,
    CMD_RECORD,
    CMD_RESELECT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        part;
    logic [4:0]  path;
    logic [31:0] lat;
    logic [31:0] rf;
  } cmd_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_MOD,
    FE_PUSH
  } fe_state_e;

  typedef enum logic [3:0] {
    BE_IDLE,
    BE_REC_RING,
    BE_REC_SMP,
    BE_REC_WR,
    BE_RS_RD,
    BE_RS_AVG,
    BE_RS_AVGW,
    BE_RS_WW,
    BE_RS_MULLO,
    BE_RS_MULHI,
    BE_RS_TGT,
    BE_RS_SRD,
    BE_RS_SCMP,
    BE_EMIT
  } be_state_e;

endpackage

// ===== rtl/lwps_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
interface lwps_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        partition;
  logic [4:0]  path_index;
  logic [31:0] latency_ns;
  logic [31:0] slot_number;
  logic [31:0] random_fraction;

  modport source (
    output valid, action, partition, path_index, latency_ns, slot_number, random_fraction,
    input  ready
  );
  modport sink (
    input  valid, action, partition, path_index, latency_ns, slot_number, random_fraction,
    output ready
  );
endinterface

interface lwps_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] chosen_path;
  logic       reselected;

  modport source (
    output valid, chosen_path, reselected,
    input  ready
  );
  modport sink (
    input  valid, chosen_path, reselected,
    output ready
  );
endinterface

// ===== rtl/latency_weighted_path_select_core.sv =====
// Top level of the latency weighted path selector with its register port.
`timescale 1ns / 1ps
// Usage: input transactions arrive on in_ch_i (valid/ready). action 0 records a
// latency sample for (partition, path_index); action 1 is a slot event that
// reselects the shared current path when slot_number is a multiple of
// update_period. Every input transaction yields exactly one result on out_ch_o
// with the current chosen_path and a reselected flag, in input order.
// Operation: the front end registers each item and, for slot events, takes the
// slot remainder bit-serially. The back end reads and writes the ring state and
// sample memory for a record and passes an ignored item on. A reselection walks
// num_paths rings: per path up to two passes of the shared iterative divider,
// then a scan of the weights. Items are handled one at a time per stage;
// the command queue lets the front end take the next item meanwhile.
// Reset clears registers to their default values and all rings to empty at
// once; no memory sweep is needed. A stalled receiver holds the result in the
// output register; the back end then waits and the queue and front end fill.
module latency_weighted_path_select_core #(
  parameter int unsigned SAMPLES    = 256,
  parameter int unsigned MAX_PATHS  = 24,
  parameter int unsigned PARTITIONS = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lwps_in_if.sink                       in_ch_i,
  lwps_out_if.source                    out_ch_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lwps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  logic [4:0]  num_paths_q;
  logic [15:0] update_period_q;
  logic [31:0] empty_latency_q;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  logic           push, full, pop, empty;
  lwps_pkg::cmd_t push_cmd, pop_cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_paths_q     <= lwps_pkg::NUM_PATHS_RST;
      update_period_q <= lwps_pkg::UPDATE_PERIOD_RST;
      empty_latency_q <= lwps_pkg::EMPTY_LATENCY_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        lwps_pkg::REG_NUM_PATHS:     num_paths_q     <= pwdata[4:0];
        lwps_pkg::REG_UPDATE_PERIOD: update_period_q <= pwdata[15:0];
        lwps_pkg::REG_EMPTY_LATENCY: empty_latency_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lwps_pkg::REG_NUM_PATHS:     prdata = 32'(num_paths_q);
      lwps_pkg::REG_UPDATE_PERIOD: prdata = 32'(update_period_q);
      lwps_pkg::REG_EMPTY_LATENCY: prdata = empty_latency_q;
      default:                     prdata = '0;
    endcase
  end

  lwps_front #(.MAX_PATHS(MAX_PATHS), .PARTITIONS(PARTITIONS)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_ch_i         (in_ch_i),
    .update_period_i (update_period_q),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  lwps_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_cmd),
    .empty_o (empty)
  );

  lwps_back #(.SAMPLES(SAMPLES), .MAX_PATHS(MAX_PATHS), .PARTITIONS(PARTITIONS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .num_paths_i     (num_paths_q),
    .empty_latency_i (empty_latency_q),
    .empty_i         (empty),
    .cmd_i           (pop_cmd),
    .pop_o           (pop),
    .out_ch_o        (out_ch_o)
  );
endmodule

// ===== rtl/lwps_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module lwps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/lwps_fifo.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module lwps_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lwps_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output lwps_pkg::cmd_t data_o,
  output logic          empty_o
);
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lwps_pkg::cmd_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("command queue underflow");
endmodule

// ===== rtl/lwps_front.sv =====
// Front end: accepts input transactions, checks slot period, queues commands.
`timescale 1ns / 1ps
module lwps_front #(
  parameter int unsigned MAX_PATHS  = 24,
  parameter int unsigned PARTITIONS = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lwps_in_if.sink        in_ch_i,
  input  logic [15:0]    update_period_i,
  input  logic           full_i,
  output logic           push_o,
  output lwps_pkg::cmd_t cmd_o
);
  lwps_pkg::fe_state_e state_q, state_d;
  lwps_pkg::cmd_t      cmd_q;
  logic [lwps_pkg::SLOT_W-1:0] slot_q;
  logic [15:0]                 rem_q;
  logic [15:0]                 rem_next;
  logic [16:0]                 trial;
  logic [lwps_pkg::STEP_W-1:0] step_q;
  logic                        accept, part_ok, rec_ok, last_step;

  assign part_ok   = (32'(in_ch_i.partition) < PARTITIONS);
  assign rec_ok    = (in_ch_i.latency_ns != '0) && (32'(in_ch_i.path_index) < MAX_PATHS);
  assign accept    = in_ch_i.valid && in_ch_i.ready;
  assign last_step = (step_q == lwps_pkg::STEP_W'(lwps_pkg::SLOT_W - 1));

  // Restoring remainder step: shift in the next slot bit
  assign trial    = {rem_q, slot_q[lwps_pkg::SLOT_W-1]};
  assign rem_next = (trial >= {1'b0, update_period_i}) ?
                    16'(trial - {1'b0, update_period_i}) : trial[15:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      lwps_pkg::FE_IDLE: begin
        if (in_ch_i.valid) begin
          if (in_ch_i.action == lwps_pkg::ACT_SLOT && part_ok && update_period_i != '0) begin
            state_d = lwps_pkg::FE_MOD;
          end else begin
            state_d = lwps_pkg::FE_PUSH;
          end
        end
      end
      lwps_pkg::FE_MOD: begin
        if (last_step) begin
          state_d = lwps_pkg::FE_PUSH;
        end
      end
      lwps_pkg::FE_PUSH: begin
        if (!full_i) begin
          state_d = lwps_pkg::FE_IDLE;
        end
      end
      default: state_d = lwps_pkg::FE_IDLE;
    endcase
  end

  always_comb begin
    in_ch_i.ready = 1'b0;
    push_o        = 1'b0;
    case (state_q)
      lwps_pkg::FE_IDLE: in_ch_i.ready = 1'b1;
      lwps_pkg::FE_PUSH: push_o = !full_i;
      default: ;
    endcase
  end

  assign cmd_o = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lwps_pkg::FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.part <= in_ch_i.partition;
      cmd_q.path <= in_ch_i.path_index;
      cmd_q.lat  <= in_ch_i.latency_ns;
      cmd_q.rf   <= in_ch_i.random_fraction;
      if (part_ok && in_ch_i.action == lwps_pkg::ACT_RECORD && rec_ok) begin
        cmd_q.kind <= lwps_pkg::CMD_RECORD;
      end else begin
        cmd_q.kind <= lwps_pkg::CMD_IGNORE;
      end
      slot_q <= in_ch_i.slot_number;
      rem_q  <= '0;
      step_q <= '0;
    end else if (state_q == lwps_pkg::FE_MOD) begin
      slot_q <= {slot_q[lwps_pkg::SLOT_W-2:0], 1'b0};
      rem_q  <= rem_next;
      step_q <= step_q + lwps_pkg::STEP_W'(1);
      if (last_step && rem_next == '0) begin
        cmd_q.kind <= lwps_pkg::CMD_RESELECT;
      end
    end
  end
endmodule

// ===== rtl/lwps_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lwps_div #(
  parameter int unsigned W = 41
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [W-1:0] quot_o
);
  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_q, quo_q, dvs_q;
  logic [W:0]       trial;
  logic             take;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  assign trial  = {rem_q, quo_q[W-1]};
  assign take   = (trial >= {1'b0, dvs_q});
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? W'(trial - {1'b0, dvs_q}) : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], take};
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
endmodule

// ===== rtl/lwps_back.sv =====
// Back end: sample rings, per-path weights and weighted random path choice.
`timescale 1ns / 1ps
module lwps_back #(
  parameter int unsigned SAMPLES    = 256,
  parameter int unsigned MAX_PATHS  = 24,
  parameter int unsigned PARTITIONS = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [4:0]     num_paths_i,
  input  logic [31:0]    empty_latency_i,
  input  logic           empty_i,
  input  lwps_pkg::cmd_t cmd_i,
  output logic           pop_o,
  lwps_out_if.source     out_ch_o
);
  localparam int unsigned SMP_W      = $clog2(SAMPLES);
  localparam int unsigned RINGS      = PARTITIONS * MAX_PATHS;
  localparam int unsigned RING_W     = (RINGS > 1) ? $clog2(RINGS) : 1;
  localparam int unsigned SUM_W      = 32 + SMP_W;
  localparam int unsigned CNT_W      = $clog2(SAMPLES + 1);
  localparam int unsigned WEIGHT_W   = lwps_pkg::WEIGHT_W;
  localparam int unsigned DIV_W      = (SUM_W > WEIGHT_W) ? SUM_W : WEIGHT_W;
  localparam int unsigned SMEM_DEPTH = RINGS * SAMPLES;
  localparam int unsigned SMEM_AW    = $clog2(SMEM_DEPTH);
  localparam int unsigned PIDX_W     = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
  localparam int unsigned NP_W       = $clog2(MAX_PATHS + 1);
  localparam int unsigned TOT_W      = WEIGHT_W + NP_W;
  localparam int unsigned RE_W       = 1 + SMP_W + SUM_W;
  localparam logic [DIV_W-1:0] WEIGHT_NUM = {{(DIV_W-1){1'b0}}, 1'b1} << lwps_pkg::WEIGHT_SHIFT;

  lwps_pkg::be_state_e state_q, state_d;
  lwps_pkg::cmd_t      cmd_q;

  // Ring state memory: {wrapped, write position, running sum}
  logic              ring_we;
  logic [RING_W-1:0] ring_waddr, ring_raddr;
  logic [RE_W-1:0]   ring_wdata, ring_rdata;
  logic [RINGS-1:0]  ring_vld_q;
  logic              rvld_q;

  logic               smp_we;
  logic [SMEM_AW-1:0] smp_waddr, smp_raddr;
  logic [31:0]        smp_rdata;

  logic                wt_we;
  logic [PIDX_W-1:0]   wt_addr;
  logic [WEIGHT_W-1:0] wt_wdata, wt_rdata;

  logic             div_start, div_busy, div_done;
  logic [DIV_W-1:0] div_a, div_b, div_q;

  logic [RING_W-1:0] rec_ring, rs_ring;
  logic              rd_wrap;
  logic [SMP_W-1:0]  rd_pos;
  logic [SUM_W-1:0]  rd_sum;
  logic [CNT_W-1:0]  rd_cnt;
  logic              rwrap_q;
  logic [SMP_W-1:0]  rpos_q;
  logic [SUM_W-1:0]  rsum_q;
  logic              pos_last;
  logic [31:0]       old_smp;
  logic [SUM_W-1:0]  new_sum;

  logic [NP_W-1:0]  n_eff, i_q, i_next;
  logic [31:0]      empty_avg;
  logic [DIV_W-1:0] avg_fix;
  logic [TOT_W-1:0] total_q, p_hi_q, target_q, prefix_q, prefix_next;
  logic [63:0]      p_lo_q;
  logic             last_path, found;
  logic [4:0]       cur_path_q;
  logic             resel_q;
  logic             out_vld_q, out_resel_q, out_free;
  logic [4:0]       out_path_q;

  lwps_ram #(.WIDTH(RE_W), .DEPTH(RINGS)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  lwps_ram #(.WIDTH(32), .DEPTH(SMEM_DEPTH)) u_smp_ram (
    .clk_i   (clk_i),
    .we_i    (smp_we),
    .waddr_i (smp_waddr),
    .wdata_i (cmd_q.lat),
    .raddr_i (smp_raddr),
    .rdata_o (smp_rdata)
  );

  lwps_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_PATHS)) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i (wt_addr),
    .wdata_i (wt_wdata),
    .raddr_i (wt_addr),
    .rdata_o (wt_rdata)
  );

  lwps_div #(.W(DIV_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  assign rec_ring = RING_W'(32'(cmd_q.part) * MAX_PATHS + 32'(cmd_q.path));
  assign rs_ring  = RING_W'(32'(cmd_q.part) * MAX_PATHS + 32'(i_q));

  // A ring never written reads as empty at position zero
  assign rd_wrap = rvld_q & ring_rdata[RE_W-1];
  assign rd_pos  = rvld_q ? ring_rdata[SUM_W +: SMP_W] : '0;
  assign rd_sum  = rvld_q ? ring_rdata[SUM_W-1:0] : '0;
  assign rd_cnt  = rd_wrap ? CNT_W'(SAMPLES) : CNT_W'(rd_pos);

  assign pos_last = (rpos_q == SMP_W'(SAMPLES - 1));
  assign old_smp  = rwrap_q ? smp_rdata : '0;
  assign new_sum  = rsum_q - SUM_W'(old_smp) + SUM_W'(cmd_q.lat);

  always_comb begin
    if (num_paths_i == '0) begin
      n_eff = NP_W'(1);
    end else if (32'(num_paths_i) > MAX_PATHS) begin
      n_eff = NP_W'(MAX_PATHS);
    end else begin
      n_eff = NP_W'(num_paths_i);
    end
  end

  assign empty_avg   = (empty_latency_i == '0) ? 32'd1 : empty_latency_i;
  assign avg_fix     = (div_q == '0) ? DIV_W'(1) : div_q;
  assign i_next      = i_q + NP_W'(1);
  assign last_path   = (i_next == n_eff);
  assign prefix_next = prefix_q + TOT_W'(wt_rdata);
  assign found       = (prefix_next >= target_q) || last_path;
  assign out_free    = !out_vld_q || out_ch_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lwps_pkg::BE_IDLE: begin
        if (!empty_i) begin
          case (cmd_i.kind)
            lwps_pkg::CMD_RECORD:   state_d = lwps_pkg::BE_REC_RING;
            lwps_pkg::CMD_RESELECT: state_d = lwps_pkg::BE_RS_RD;
            default:                state_d = lwps_pkg::BE_EMIT;
          endcase
        end
      end
      lwps_pkg::BE_REC_RING: state_d = lwps_pkg::BE_REC_SMP;
      lwps_pkg::BE_REC_SMP:  state_d = lwps_pkg::BE_REC_WR;
      lwps_pkg::BE_REC_WR:   state_d = lwps_pkg::BE_EMIT;
      lwps_pkg::BE_RS_RD:    state_d = lwps_pkg::BE_RS_AVG;
      lwps_pkg::BE_RS_AVG: begin
        state_d = (rd_cnt == '0) ? lwps_pkg::BE_RS_WW : lwps_pkg::BE_RS_AVGW;
      end
      lwps_pkg::BE_RS_AVGW: begin
        if (div_done) begin
          state_d = lwps_pkg::BE_RS_WW;
        end
      end
      lwps_pkg::BE_RS_WW: begin
        if (div_done) begin
          state_d = last_path ? lwps_pkg::BE_RS_MULLO : lwps_pkg::BE_RS_RD;
        end
      end
      lwps_pkg::BE_RS_MULLO: state_d = lwps_pkg::BE_RS_MULHI;
      lwps_pkg::BE_RS_MULHI: state_d = lwps_pkg::BE_RS_TGT;
      lwps_pkg::BE_RS_TGT:   state_d = lwps_pkg::BE_RS_SRD;
      lwps_pkg::BE_RS_SRD:   state_d = lwps_pkg::BE_RS_SCMP;
      lwps_pkg::BE_RS_SCMP: begin
        state_d = found ? lwps_pkg::BE_EMIT : lwps_pkg::BE_RS_SRD;
      end
      lwps_pkg::BE_EMIT: begin
        if (out_free) begin
          state_d = lwps_pkg::BE_IDLE;
        end
      end
      default: state_d = lwps_pkg::BE_IDLE;
    endcase
  end

  always_comb begin
    pop_o      = 1'b0;
    ring_we    = 1'b0;
    smp_we     = 1'b0;
    wt_we      = 1'b0;
    div_start  = 1'b0;
    div_a      = WEIGHT_NUM;
    div_b      = avg_fix;
    ring_raddr = rs_ring;
    ring_waddr = rec_ring;
    ring_wdata = {rwrap_q | pos_last, pos_last ? SMP_W'(0) : rpos_q + SMP_W'(1), new_sum};
    smp_raddr  = SMEM_AW'(32'(rec_ring) * SAMPLES + 32'(rd_pos));
    smp_waddr  = SMEM_AW'(32'(rec_ring) * SAMPLES + 32'(rpos_q));
    wt_addr    = PIDX_W'(i_q);
    wt_wdata   = div_q[WEIGHT_W-1:0];
    case (state_q)
      lwps_pkg::BE_IDLE:     pop_o = !empty_i;
      lwps_pkg::BE_REC_RING: ring_raddr = rec_ring;
      lwps_pkg::BE_REC_WR: begin
        ring_we = 1'b1;
        smp_we  = 1'b1;
      end
      lwps_pkg::BE_RS_AVG: begin
        div_start = 1'b1;
        if (rd_cnt == '0) begin
          div_b = DIV_W'(empty_avg);
        end else begin
          div_a = DIV_W'(rd_sum);
          div_b = DIV_W'(rd_cnt);
        end
      end
      lwps_pkg::BE_RS_AVGW: div_start = div_done;
      lwps_pkg::BE_RS_WW:   wt_we = div_done;
      default: ;
    endcase
  end

  assign out_ch_o.valid       = out_vld_q;
  assign out_ch_o.chosen_path = out_path_q;
  assign out_ch_o.reselected  = out_resel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lwps_pkg::BE_IDLE;
      ring_vld_q <= '0;
      cur_path_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lwps_pkg::BE_REC_WR) begin
        ring_vld_q[rec_ring] <= 1'b1;
      end
      if (state_q == lwps_pkg::BE_RS_SCMP && found) begin
        cur_path_q <= 5'(i_q);
      end
      if (state_q == lwps_pkg::BE_EMIT && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rvld_q <= ring_vld_q[ring_raddr];
    case (state_q)
      lwps_pkg::BE_IDLE: begin
        cmd_q    <= cmd_i;
        resel_q  <= (cmd_i.kind == lwps_pkg::CMD_RESELECT);
        i_q      <= '0;
        total_q  <= '0;
      end
      lwps_pkg::BE_REC_SMP: begin
        rwrap_q <= rd_wrap;
        rpos_q  <= rd_pos;
        rsum_q  <= rd_sum;
      end
      lwps_pkg::BE_RS_WW: begin
        if (div_done) begin
          total_q <= total_q + TOT_W'(div_q[WEIGHT_W-1:0]);
          i_q     <= i_next;
        end
      end
      lwps_pkg::BE_RS_MULLO: begin
        p_lo_q <= 64'(cmd_q.rf) * 64'(total_q[31:0]);
      end
      lwps_pkg::BE_RS_MULHI: begin
        p_hi_q <= TOT_W'(cmd_q.rf) * TOT_W'(total_q[TOT_W-1:32]);
      end
      lwps_pkg::BE_RS_TGT: begin
        target_q <= p_hi_q + TOT_W'(p_lo_q[63:32]);
        prefix_q <= '0;
        i_q      <= '0;
      end
      lwps_pkg::BE_RS_SCMP: begin
        prefix_q <= prefix_next;
        i_q      <= i_next;
      end
      lwps_pkg::BE_EMIT: begin
        if (out_free) begin
          out_path_q  <= cur_path_q;
          out_resel_q <= resel_q;
        end
      end
      default: ;
    endcase
  end

  a_path_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_path_q) < MAX_PATHS) else $error("selected path out of range");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lwps_pkg::BE_RS_SCMP |-> i_q < n_eff) else $error("weight scan overran");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("division issued while divider busy");
endmodule

// ===== verif/tb_latency_weighted_path_select_core.sv =====
// Testbench for the latency weighted path selector: directed table, random phases, scoreboard.
`timescale 1ns / 1ps
module tb_latency_weighted_path_select_core;

  localparam int unsigned RINGS_SAMPLES = 256;
  localparam int unsigned PATHS_MAX     = 24;
  localparam int unsigned GROUPS        = 2;
  localparam int unsigned CYCLE_LIMIT   = 6000000;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam int unsigned HOLD_CYCLES   = 3000;
  localparam int unsigned ROW_COUNT     = 15;

  typedef struct {
    logic        action;
    logic        part;
    logic [4:0]  path;
    logic [31:0] lat;
    logic [31:0] slot;
    logic [31:0] rf;
    bit          known;
    logic [4:0]  exp_path;
    logic        exp_resel;
  } stim_row_t;

  typedef struct {
    logic [4:0] path;
    logic       resel;
  } choice_t;

  typedef struct {
    logic [31:0] np;
    logic [31:0] period;
    logic [31:0] empty;
    bit          narrow;
    bit          no_gaps;
  } phase_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [lwps_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  lwps_in_if  in_ch();
  lwps_out_if out_ch();

  latency_weighted_path_select_core DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state
  logic [31:0] ring_mem [GROUPS*PATHS_MAX*RINGS_SAMPLES];
  logic [7:0]  ring_pos [GROUPS*PATHS_MAX];
  logic [4:0]  cur_path;
  logic [4:0]  cfg_np;
  logic [15:0] cfg_period;
  logic [31:0] cfg_empty;

  choice_t expected_choices[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit hold_req;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] inverse_latency_weight(int unsigned g, int unsigned p);
    logic [63:0] sum;
    logic [63:0] cnt;
    logic [63:0] avg;
    int unsigned base;
    sum = 0;
    cnt = 0;
    base = (g * PATHS_MAX + p) * RINGS_SAMPLES;
    for (int j = 0; j < RINGS_SAMPLES; j++) begin
      sum += 64'(ring_mem[base + j]);
      if (ring_mem[base + j] != 0) cnt++;
    end
    if (cnt == 0) avg = (cfg_empty == 0) ? 64'd1 : {32'd0, cfg_empty};
    else avg = sum / cnt;
    if (avg == 0) avg = 1;
    return (64'd1 << 40) / avg;
  endfunction

  function automatic choice_t predict_path_choice(stim_row_t s);
    choice_t r;
    logic [63:0] w [PATHS_MAX];
    logic [63:0] total, target, prefix, rf64;
    int unsigned n, pick, ring;
    r.resel = 1'b0;
    if (s.action == lwps_pkg::ACT_RECORD) begin
      if (s.lat != 0 && s.path < PATHS_MAX) begin
        ring = s.part * PATHS_MAX + s.path;
        ring_mem[ring * RINGS_SAMPLES + ring_pos[ring]] = s.lat;
        ring_pos[ring] = ring_pos[ring] + 8'd1;
      end
    end else if (cfg_period != 0 && (s.slot % cfg_period) == 0) begin
      n = (cfg_np == 0) ? 1 : ((cfg_np > PATHS_MAX) ? PATHS_MAX : cfg_np);
      total = 0;
      for (int i = 0; i < n; i++) begin
        w[i] = inverse_latency_weight(s.part, i);
        total += w[i];
      end
      rf64 = {32'd0, s.rf};
      target = rf64 * (total >> 32) + ((rf64 * (total & 64'hFFFF_FFFF)) >> 32);
      pick = n - 1;
      prefix = 0;
      for (int i = 0; i < n; i++) begin
        prefix += w[i];
        if (prefix >= target) begin
          pick = i;
          break;
        end
      end
      cur_path = pick[4:0];
      r.resel = 1'b1;
    end
    r.path = cur_path;
    return r;
  endfunction

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lwps_pkg::REG_NUM_PATHS:     cfg_np = value[4:0];
      lwps_pkg::REG_UPDATE_PERIOD: cfg_period = value[15:0];
      lwps_pkg::REG_EMPTY_LATENCY: cfg_empty = value;
      default: ;
    endcase
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offer one transaction and queue its expectation once accepted
  task automatic send_item(stim_row_t s, bit gaps);
    choice_t c;
    int unsigned g;
    g = gaps ? idle_len() : 0;
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.action          <= s.action;
    in_ch.partition       <= s.part;
    in_ch.path_index      <= s.path;
    in_ch.latency_ns      <= s.lat;
    in_ch.slot_number     <= s.slot;
    in_ch.random_fraction <= s.rf;
    do @(posedge clk_i); while (!in_ch.ready);
    c = predict_path_choice(s);
    if (s.known) begin
      c.path  = s.exp_path;
      c.resel = s.exp_resel;
    end
    expected_choices = {expected_choices, c};
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_choices.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic stim_row_t random_item(bit narrow);
    stim_row_t s;
    int unsigned n, r;
    n = (cfg_np == 0) ? 1 : ((cfg_np > PATHS_MAX) ? PATHS_MAX : cfg_np);
    s.known  = 0;
    s.action = ($urandom_range(0, 99) < (narrow ? 85 : 50)) ? lwps_pkg::ACT_RECORD
                                                            : lwps_pkg::ACT_SLOT;
    s.part   = 1'($urandom_range(0, 1));
    if (narrow) s.path = 5'($urandom_range(0, 1));
    else if ($urandom_range(0, 99) < 85) s.path = 5'($urandom_range(0, n - 1));
    else s.path = 5'($urandom_range(0, 31));
    r = $urandom_range(0, 99);
    if (r < 8) s.lat = 32'd0;
    else if (r < 13) s.lat = 32'hFFFF_FFFF;
    else if (r < 70) s.lat = $urandom_range(1, 5000);
    else s.lat = $urandom;
    if (cfg_period != 0 && $urandom_range(0, 99) < 70)
      s.slot = cfg_period * $urandom_range(0, 65535);
    else
      s.slot = $urandom;
    r = $urandom_range(0, 19);
    s.rf = (r == 0) ? 32'd0 : ((r == 1) ? 32'hFFFF_FFFF : $urandom);
    s.exp_path  = '0;
    s.exp_resel = 1'b0;
    return s;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    choice_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_choices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result path=%0d resel=%0b",
                                       out_ch.chosen_path, out_ch.reselected);
      end else begin
        e = expected_choices.pop_front();
        if (out_ch.chosen_path !== e.path || out_ch.reselected !== e.resel) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp path=%0d resel=%0b, got path=%0d resel=%0b",
                     e.path, e.resel, out_ch.chosen_path, out_ch.reselected);
        end
      end
    end
  end

  // Result receiver with random stalls and one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 0;
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        if ($urandom_range(0, 1)) begin
          out_ch.ready <= 1'b0;
          repeat (idle_len() + 1) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    stim_row_t rows[ROW_COUNT];
    stim_row_t s;
    phase_t phases[6];

    mismatches = 0;
    cycles = 0;
    hold_req = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = lwps_pkg::ACT_RECORD;
    in_ch.partition = 1'b0;
    in_ch.path_index = '0;
    in_ch.latency_ns = '0;
    in_ch.slot_number = '0;
    in_ch.random_fraction = '0;
    cfg_np = lwps_pkg::NUM_PATHS_RST;
    cfg_period = lwps_pkg::UPDATE_PERIOD_RST;
    cfg_empty = lwps_pkg::EMPTY_LATENCY_RST;
    cur_path = '0;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    foreach (ring_pos[i]) ring_pos[i] = '0;

    //         act                    pt    path   lat           slot          rf
    //         known path resel
    rows[0]  = '{lwps_pkg::ACT_RECORD, 1'b0, 5'd0,  32'd0,        32'd0,        32'd0,
                 1'b1, 5'd0, 1'b0};
    rows[1]  = '{lwps_pkg::ACT_SLOT,   1'b0, 5'd0,  32'd0,        32'd1,        32'd0,
                 1'b1, 5'd0, 1'b0};
    rows[2]  = '{lwps_pkg::ACT_SLOT,   1'b0, 5'd0,  32'd0,        32'd0,        32'd0,
                 1'b1, 5'd0, 1'b1};
    rows[3]  = '{lwps_pkg::ACT_SLOT,   1'b0, 5'd0,  32'd0,        32'd0,        32'hFFFFFFFF,
                 1'b1, 5'd1, 1'b1};
    rows[4]  = '{lwps_pkg::ACT_RECORD, 1'b1, 5'd31, 32'hFFFFFFFF, 32'd0,        32'd0,
                 1'b1, 5'd1, 1'b0};
    rows[5]  = '{lwps_pkg::ACT_RECORD, 1'b0, 5'd24, 32'd5,        32'd0,        32'd0,
                 1'b1, 5'd1, 1'b0};
    rows[6]  = '{lwps_pkg::ACT_RECORD, 1'b0, 5'd23, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                 1'b1, 5'd1, 1'b0};
    rows[7]  = '{lwps_pkg::ACT_RECORD, 1'b0, 5'd0,  32'd1,        32'd0,        32'd0,
                 1'b1, 5'd1, 1'b0};
    rows[8]  = '{lwps_pkg::ACT_RECORD, 1'b0, 5'd1,  32'hFFFFFFFF, 32'd0,        32'd0,
                 1'b1, 5'd1, 1'b0};
    rows[9]  = '{lwps_pkg::ACT_SLOT,   1'b0, 5'd0,  32'd0,        32'd2000,     32'h80000000,
                 1'b0, 5'd0, 1'b0};
    rows[10] = '{lwps_pkg::ACT_SLOT,   1'b0, 5'd0,  32'd0,        32'hFFFFFFFF, 32'd0,
                 1'b0, 5'd0, 1'b0};
    rows[11] = '{lwps_pkg::ACT_SLOT,   1'b0, 5'd0,  32'd0,        32'd1000,     32'hFFFFFFFF,
                 1'b0, 5'd0, 1'b0};
    rows[12] = '{lwps_pkg::ACT_RECORD, 1'b1, 5'd1,  32'd100,      32'd0,        32'd0,
                 1'b0, 5'd0, 1'b0};
    rows[13] = '{lwps_pkg::ACT_SLOT,   1'b1, 5'd31, 32'hFFFFFFFF, 32'd3000,     32'h40000000,
                 1'b0, 5'd0, 1'b0};
    rows[14] = '{lwps_pkg::ACT_SLOT,   1'b1, 5'd0,  32'd0,        32'd999,      32'h12345678,
                 1'b0, 5'd0, 1'b0};

    phases[0] = '{32'd1,  32'd1,     32'd1,         1'b0, 1'b0};
    phases[1] = '{32'd24, 32'd7,     32'd0,         1'b0, 1'b0};
    phases[2] = '{32'd3,  32'd65535, 32'hFFFFFFFF,  1'b0, 1'b1};
    phases[3] = '{32'd0,  32'd0,     32'd5000,      1'b0, 1'b0};
    phases[4] = '{32'd31, 32'd3,     32'd1000000,   1'b0, 1'b0};
    phases[5] = '{32'd2,  32'd1,     32'd100,       1'b1, 1'b0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i], 1);
    wait_idle();

    foreach (phases[p]) begin
      reg_write(lwps_pkg::REG_NUM_PATHS, phases[p].np);
      reg_write(lwps_pkg::REG_UPDATE_PERIOD, phases[p].period);
      reg_write(lwps_pkg::REG_EMPTY_LATENCY, phases[p].empty);
      // Stall the receiver for a long stretch while items keep coming
      if (p == 0) hold_req = 1;
      for (int k = 0; k < (phases[p].narrow ? 360 : 150); k++) begin
        s = random_item(phases[p].narrow);
        send_item(s, !phases[p].no_gaps);
      end
      wait_idle();
    end

    if (mismatches == 0 && expected_choices.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lwps_pkg.sv
rtl/lwps_if.sv
rtl/lwps_ram.sv
rtl/lwps_fifo.sv
rtl/lwps_front.sv
rtl/lwps_div.sv
rtl/lwps_back.sv
rtl/latency_weighted_path_select_core.sv
verif/tb_latency_weighted_path_select_core.sv
